>>> rtl/table_driven_byte_automaton_macros.svh
// Assertion macros used by the automaton RTL.
`ifndef TABLE_DRIVEN_BYTE_AUTOMATON_MACROS_SVH
`define TABLE_DRIVEN_BYTE_AUTOMATON_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TDBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TDBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tdba_pkg.sv
// ----------------------------------------------------------------------------
// tdba_pkg
// Types, codes and helper functions of the table driven byte automaton.
// ----------------------------------------------------------------------------
package tdba_pkg;

    // default table sizes
    localparam int NumStatesDef      = 256;
    localparam int NumTransitionsDef = 1024;
    localparam int NumPathsDef       = 64;
    localparam int PathLenDef        = 32;
    localparam int MaxRefeedDef      = 8;

    // item function codes
    localparam logic [2:0] FUNC_WR_STATE = 3'd0;
    localparam logic [2:0] FUNC_WR_TRANS = 3'd1;
    localparam logic [2:0] FUNC_WR_PATH  = 3'd2;
    localparam logic [2:0] FUNC_FEED     = 3'd3;
    localparam logic [2:0] FUNC_RESTART  = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_EVENT    = 3'd0;
    localparam logic [2:0] KIND_ACCEPTED = 3'd1;
    localparam logic [2:0] KIND_NO_TRANS = 3'd2;
    localparam logic [2:0] KIND_REFEED   = 3'd3;
    localparam logic [2:0] KIND_DONE     = 3'd4;

    // transition types and special classes
    localparam logic [1:0] TT_EXACT  = 2'd0;
    localparam logic [1:0] TT_NOCASE = 2'd1;
    localparam logic [1:0] TT_CLASS  = 2'd2;
    localparam logic [7:0] CLS_ANY   = 8'd0;
    localparam logic [7:0] CLS_SPACE = 8'd1;
    localparam logic [7:0] CLS_BLANK = 8'd2;
    localparam logic [7:0] CLS_DIGIT = 8'd3;

    // characters
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_HT  = 8'h09;

    typedef enum logic [3:0] {
        S_IDLE, S_PASS, S_E, S_P, S_P2, S_T_RD, S_T_CHK,
        S_EV_RD, S_EV_EN, S_EMIT_EV, S_NEXT, S_FIN
    } t_state;

    function automatic logic [7:0] lower_ascii(input logic [7:0] b);
        lower_ascii = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    function automatic logic trans_match(input logic [18:0] t, input logic [7:0] b);
        logic [7:0] lbl;
        lbl = t[9:2];
        unique case (t[1:0])
            TT_EXACT:  trans_match = (b == lbl);
            TT_NOCASE: trans_match = (lower_ascii(b) == lbl);
            TT_CLASS: begin
                priority case (lbl)
                    CLS_ANY:   trans_match = 1'b1;
                    CLS_SPACE: trans_match = (b == CH_SP) || (b >= 8'd9 && b <= 8'd13);
                    CLS_BLANK: trans_match = (b == CH_SP) || (b == CH_HT);
                    CLS_DIGIT: trans_match = (b >= 8'h30 && b <= 8'h39);
                    default:   trans_match = 1'b0;
                endcase
            end
            default: trans_match = 1'b0;
        endcase
    endfunction

endpackage

>>> rtl/table_driven_byte_automaton.sv
// ----------------------------------------------------------------------------
// table_driven_byte_automaton
// Programmable byte-stream automaton held in three table memories.
// ----------------------------------------------------------------------------
// One item at a time. Loads and restarts go straight to the result. A feed
// pass reads the state entry, its successor and the path char, reads one more
// path char when it matches, reads then compares each transition entry
// scanned, and reads the enter flag once a target state is chosen; a
// fallthrough repeats the pass, up to MAX_REFEED passes in all. Each result
// waits on the output register. The single-port transition scan sets the rate.
module table_driven_byte_automaton #(
    parameter int NUM_STATES      = tdba_pkg::NumStatesDef,
    parameter int NUM_TRANSITIONS = tdba_pkg::NumTransitionsDef,
    parameter int NUM_PATHS       = tdba_pkg::NumPathsDef,
    parameter int PATH_LEN        = tdba_pkg::PathLenDef,
    parameter int MAX_REFEED      = tdba_pkg::MaxRefeedDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_func,
    input  logic [10:0] i_index,
    input  logic [19:0] i_entry,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_from_state,
    output logic [7:0]  o_to_state,
    output logic        o_left_old,
    output logic        o_entered_new,
    output logic [7:0]  o_payload,
    output logic        o_last
);

    localparam int SAW  = $clog2(NUM_STATES + 1);
    localparam int TAW  = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
    localparam int PIDW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
    localparam int PAW  = PIDW + 5;
    localparam logic [8:0]  NS9  = 9'(NUM_STATES);
    localparam logic [10:0] NT11 = 11'(NUM_TRANSITIONS);
    localparam logic [6:0]  NP7  = 7'(NUM_PATHS);
    localparam logic [5:0]  PL6  = 6'(PATH_LEN);
    localparam logic [3:0]  MR4  = 4'(MAX_REFEED);

    tdba_pkg::t_state r_st, n_st;

    logic [7:0]  r_start;
    logic [7:0]  r_cur, n_cur;
    logic [4:0]  r_pos, n_pos;
    logic [7:0]  r_b, n_b;
    logic [7:0]  r_from, n_from;
    logic [19:0] r_e, n_e;
    logic [9:0]  r_hi, n_hi;
    logic [9:0]  r_ti, n_ti;
    logic        r_ptry, n_ptry;
    logic [7:0]  r_nst, n_nst;
    logic        r_ft, n_ft;
    logic        r_en, n_en;
    logic [3:0]  r_pass, n_pass;
    logic [2:0]  r_fkind, n_fkind;

    // output register
    logic        r_ov;
    logic [2:0]  r_kind;
    logic [7:0]  r_ofrom, r_oto, r_opay;
    logic        r_olv, r_oen, r_olast;

    logic        push;
    logic [2:0]  p_kind;
    logic [7:0]  p_from, p_to, p_pay;
    logic        p_lv, p_en, p_last;

    // memory ports
    logic             st_we, st_re, tr_we, tr_re, pa_we, pa_re;
    logic [SAW-1:0]   st_waddr, st_raddr;
    logic [TAW-1:0]   tr_waddr, tr_raddr;
    logic [PAW-1:0]   pa_waddr, pa_raddr;
    logic [19:0]      st_rdata;
    logic [18:0]      tr_rdata;
    logic [7:0]       pa_rdata;

    logic             accept, can_push, s_ok;
    logic [7:0]       c_byte, s_next;
    logic [5:0]       pos_inc;
    logic [5:0]       pid;

    assign accept   = i_in_valid && !o_in_stall;
    assign can_push = !r_ov || !i_out_stall;
    assign s_ok     = {1'b0, r_cur} < NS9;
    assign c_byte   = r_e[1] ? tdba_pkg::lower_ascii(r_b) : r_b;
    assign pos_inc  = {1'b0, r_pos} + 6'd1;
    assign s_next   = ({1'b0, r_cur} + 9'd1 >= NS9) ? 8'd0 : r_cur + 8'd1;
    assign pid      = r_e[9:4];

    assign o_in_stall  = (r_st != tdba_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // table writes, taken only when an item is accepted in idle
    assign st_we    = accept && (i_func == tdba_pkg::FUNC_WR_STATE)
                      && ({2'b0, NS9} >= i_index);
    assign st_waddr = SAW'(i_index);
    assign tr_we    = accept && (i_func == tdba_pkg::FUNC_WR_TRANS) && (i_index < NT11);
    assign tr_waddr = TAW'(i_index);
    assign pa_we    = accept && (i_func == tdba_pkg::FUNC_WR_PATH)
                      && ({1'b0, i_index[10:5]} < NP7) && ({1'b0, i_index[4:0]} < PL6);
    assign pa_waddr = {PIDW'(i_index[10:5]), i_index[4:0]};

    tdba_ram #(.WIDTH(20), .DEPTH(NUM_STATES + 1), .AW(SAW)) u_state_mem (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(i_entry),
        .i_re(st_re), .i_raddr(st_raddr), .o_rdata(st_rdata)
    );
    tdba_ram #(.WIDTH(19), .DEPTH(2 ** TAW), .AW(TAW)) u_trans_mem (
        .i_clk(i_clk), .i_we(tr_we), .i_waddr(tr_waddr), .i_wdata(i_entry[18:0]),
        .i_re(tr_re), .i_raddr(tr_raddr), .o_rdata(tr_rdata)
    );
    tdba_ram #(.WIDTH(8), .DEPTH(2 ** PAW), .AW(PAW)) u_path_mem (
        .i_clk(i_clk), .i_we(pa_we), .i_waddr(pa_waddr), .i_wdata(i_entry[7:0]),
        .i_re(pa_re), .i_raddr(pa_raddr), .o_rdata(pa_rdata)
    );

    // sequencer: next state, memory reads and result pushes
    always_comb begin
        n_st = r_st;   n_cur = r_cur;   n_pos = r_pos;   n_b = r_b;
        n_from = r_from; n_e = r_e;     n_hi = r_hi;     n_ti = r_ti;
        n_ptry = r_ptry; n_nst = r_nst; n_ft = r_ft;     n_en = r_en;
        n_pass = r_pass; n_fkind = r_fkind;
        st_re = 1'b0; st_raddr = SAW'({1'b0, r_cur});
        tr_re = 1'b0; tr_raddr = TAW'(r_ti);
        pa_re = 1'b0; pa_raddr = {PIDW'(pid), r_pos};
        push = 1'b0; p_kind = r_fkind; p_from = r_from; p_to = r_cur;
        p_lv = 1'b0; p_en = 1'b0; p_pay = r_b; p_last = 1'b1;
        unique case (r_st)
            tdba_pkg::S_IDLE: begin
                if (accept) begin
                    n_from = r_cur;
                    n_b    = 8'd0;
                    n_fkind = tdba_pkg::KIND_DONE;
                    priority case (i_func)
                        tdba_pkg::FUNC_WR_STATE, tdba_pkg::FUNC_WR_TRANS,
                        tdba_pkg::FUNC_WR_PATH: n_st = tdba_pkg::S_FIN;
                        tdba_pkg::FUNC_RESTART: begin
                            n_cur = r_start;
                            n_pos = 5'd0;
                            n_st  = tdba_pkg::S_FIN;
                        end
                        tdba_pkg::FUNC_FEED: begin
                            n_b    = i_data_byte;
                            n_pass = 4'd1;
                            n_st   = tdba_pkg::S_PASS;
                        end
                        default: n_st = tdba_pkg::S_IDLE;
                    endcase
                end
            end
            tdba_pkg::S_PASS: begin
                st_re = s_ok;
                n_st  = tdba_pkg::S_E;
            end
            tdba_pkg::S_E: begin
                n_e      = s_ok ? st_rdata : 20'd0;
                st_re    = s_ok;
                st_raddr = SAW'({1'b0, r_cur} + 9'd1);
                n_ptry   = s_ok && st_rdata[0] && ({1'b0, st_rdata[9:4]} < NP7);
                pa_raddr = {PIDW'(st_rdata[9:4]), r_pos};
                pa_re    = n_ptry;
                n_st     = tdba_pkg::S_P;
            end
            tdba_pkg::S_P: begin
                n_hi = st_rdata[19:10];
                n_ti = r_e[19:10];
                if (r_ptry && (pa_rdata == c_byte)) begin
                    n_ft = 1'b0;
                    if (pos_inc >= PL6) begin
                        n_nst = s_next;
                        n_st  = tdba_pkg::S_EV_RD;
                    end else begin
                        pa_raddr = {PIDW'(pid), pos_inc[4:0]};
                        pa_re    = 1'b1;
                        n_st     = tdba_pkg::S_P2;
                    end
                end else if (s_ok) begin
                    n_st = tdba_pkg::S_T_RD;
                end else begin
                    n_fkind = tdba_pkg::KIND_NO_TRANS;
                    n_st    = tdba_pkg::S_FIN;
                end
            end
            tdba_pkg::S_P2: begin
                if (pa_rdata == tdba_pkg::CH_NUL) begin
                    n_nst = s_next;
                    n_st  = tdba_pkg::S_EV_RD;
                end else begin
                    n_pos   = pos_inc[4:0];
                    n_fkind = tdba_pkg::KIND_ACCEPTED;
                    n_st    = tdba_pkg::S_FIN;
                end
            end
            tdba_pkg::S_T_RD: begin
                if ((r_ti < r_hi) && ({1'b0, r_ti} < NT11)) begin
                    tr_re = 1'b1;
                    n_st  = tdba_pkg::S_T_CHK;
                end else begin
                    n_fkind = tdba_pkg::KIND_NO_TRANS;
                    n_st    = tdba_pkg::S_FIN;
                end
            end
            tdba_pkg::S_T_CHK: begin
                if (tdba_pkg::trans_match(tr_rdata, r_b)) begin
                    n_nst = tr_rdata[17:10];
                    n_ft  = tr_rdata[18];
                    n_st  = tdba_pkg::S_EV_RD;
                end else begin
                    n_ti = r_ti + 10'd1;
                    n_st = tdba_pkg::S_T_RD;
                end
            end
            tdba_pkg::S_EV_RD: begin
                st_raddr = SAW'({1'b0, r_nst});
                st_re    = ({1'b0, r_nst} < NS9);
                n_st     = tdba_pkg::S_EV_EN;
            end
            tdba_pkg::S_EV_EN: begin
                n_en  = ({1'b0, r_nst} < NS9) && st_rdata[3];
                n_cur = r_nst;
                n_pos = 5'd0;
                n_from = r_cur;
                n_st  = (r_e[2] || n_en) ? tdba_pkg::S_EMIT_EV : tdba_pkg::S_NEXT;
            end
            tdba_pkg::S_EMIT_EV: begin
                // from register holds the pass's old state here
                push   = can_push;
                p_kind = tdba_pkg::KIND_EVENT;
                p_from = r_from;
                p_to   = r_nst;
                p_lv   = r_e[2];
                p_en   = r_en;
                p_last = 1'b0;
                if (can_push) begin
                    n_st = tdba_pkg::S_NEXT;
                end
            end
            tdba_pkg::S_NEXT: begin
                if (!r_ft) begin
                    n_fkind = tdba_pkg::KIND_ACCEPTED;
                    n_st    = tdba_pkg::S_FIN;
                end else if (r_pass >= MR4) begin
                    n_fkind = tdba_pkg::KIND_REFEED;
                    n_st    = tdba_pkg::S_FIN;
                end else begin
                    n_pass = r_pass + 4'd1;
                    n_st   = tdba_pkg::S_PASS;
                end
            end
            tdba_pkg::S_FIN: begin
                push = can_push;
                if (can_push) begin
                    n_st = tdba_pkg::S_IDLE;
                end
            end
            default: n_st = tdba_pkg::S_IDLE;
        endcase
    end

    // start of item: keep start state for final results separately
    logic [7:0] r_istart;
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_istart <= r_cur;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= tdba_pkg::S_IDLE;
            r_start <= 8'd0;
            r_cur   <= 8'd0;
            r_pos   <= 5'd0;
            r_pass  <= 4'd0;
            r_ov    <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_cur  <= n_cur;
            r_pos  <= n_pos;
            r_pass <= n_pass;
            if (i_cfg_valid) begin
                r_start <= i_cfg_data;
            end
            if (push) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working and result payload registers
    always_ff @(posedge i_clk) begin
        r_b <= n_b;   r_from <= n_from; r_e <= n_e;   r_hi <= n_hi;
        r_ti <= n_ti; r_ptry <= n_ptry; r_nst <= n_nst; r_ft <= n_ft;
        r_en <= n_en; r_fkind <= n_fkind;
        if (push) begin
            r_kind  <= p_kind;
            r_ofrom <= p_last ? r_istart : p_from;
            r_oto   <= p_to;
            r_olv   <= p_lv;
            r_oen   <= p_en;
            r_opay  <= p_pay;
            r_olast <= p_last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_kind        = r_kind;
    assign o_from_state  = r_ofrom;
    assign o_to_state    = r_oto;
    assign o_left_old    = r_olv;
    assign o_entered_new = r_oen;
    assign o_payload     = r_opay;
    assign o_last        = r_olast;

`include "table_driven_byte_automaton_macros.svh"

    `TDBA_ASSERT_NOW(a_pass_bound, i_clk, i_rst_n, 1'b1, r_pass <= MR4, "refeed count overrun")
    `TDBA_ASSERT_NOW(a_scan_range, i_clk, i_rst_n, r_st == tdba_pkg::S_T_CHK, {1'b0, r_ti} < NT11, "scan index beyond table")
    `TDBA_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, 1'b1, {1'b0, r_pos} < PL6, "path position beyond length")
    `TDBA_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, push && p_last, r_st == tdba_pkg::S_IDLE, "final result without return to idle")

endmodule

>>> rtl/tdba_ram.sv
// ----------------------------------------------------------------------------
// tdba_ram
// Single write port, single read port table memory, registered read data.
// ----------------------------------------------------------------------------
module tdba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
